// ===== hdl/lgsg_pkg.sv =====
package lgsg_pkg;

   localparam int OP_W       = 2;
   localparam int COLOUR_W   = 32;
   localparam int POS_W      = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 72;

   localparam logic [OP_W-1:0] OP_WRITE_RAMP = 2'd0;
   localparam logic [OP_W-1:0] OP_START_SPAN = 2'd1;
   localparam logic [OP_W-1:0] OP_NEXT_PIXEL = 2'd2;

   localparam logic [1:0] MODE_PAD     = 2'd0;
   localparam logic [1:0] MODE_REPEAT  = 2'd1;
   localparam logic [1:0] MODE_REFLECT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SPREAD_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POSITION_STEP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SWAP_RED_BLUE = 2'd2;

   typedef logic [COLOUR_W-1:0] colour_type;
   typedef logic [POS_W-1:0]    position_type;

   function automatic colour_type swap_red_blue(colour_type c);
      return {c[31:24], c[7:0], c[15:8], c[23:16]};
   endfunction

   // map a gradient position to an 8-bit ramp index for the spread mode
   function automatic logic [7:0] spread_index(logic [1:0] mode, position_type pos);
      logic [7:0] idx;
      case (mode)
         MODE_PAD: begin
            if (pos[31]) begin
               idx = 8'd0;
            end else if (|pos[30:16]) begin
               idx = 8'hFF;
            end else begin
               idx = pos[15:8];
            end
         end
         MODE_REPEAT: begin
            idx = pos[22:15];
         end
         MODE_REFLECT: begin
            idx = pos[23] ? ~pos[22:15] : pos[22:15];
         end
         default: begin
            idx = pos[23] ? ~pos[22:15] : pos[22:15];
         end
      endcase
      return idx;
   endfunction

endpackage

// ===== hdl/lgsg_ram.sv =====
module lgsg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/linear_gradient_span_generator_top.sv =====
// Linear gradient span generator. Load ramp entries with write-ramp requests, set the
// spread mode, step and red/blue swap through the csr port while idle, then send a
// start-span request followed by one next-pixel request per pixel; each next-pixel
// request returns one ARGB colour on rsp. One request is taken every clock unless rsp
// back-pressure stalls the read stage; a pixel colour is registered by the ramp RAM read
// and then by the output register before it appears on rsp. The ramp powers up undefined: write every
// entry a span can reach before using it. No clearing pass runs after reset.
module linear_gradient_span_generator_top #(
   parameter int RAMP_ENTRIES = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // ramp_index[7:0], ramp_colour[39:8], start_position[71:40]
   input  logic [lgsg_pkg::REQ_DATA_W-1:0]   req_tdata,
   // op[1:0]
   input  logic [lgsg_pkg::OP_W-1:0]         req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // pixel_colour[31:0]
   output logic [lgsg_pkg::COLOUR_W-1:0]     rsp_tdata,
   input  logic                              csr_we,
   input  logic [lgsg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lgsg_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import lgsg_pkg::*;

   localparam int IDX_W = $clog2(RAMP_ENTRIES);

   typedef logic [IDX_W-1:0] ramp_addr_type;
   typedef ramp_addr_type mod_tab_type [256];

   function automatic mod_tab_type build_mod_tab();
      mod_tab_type t;
      for (int i = 0; i < 256; i++) begin
         t[i] = ramp_addr_type'(i % RAMP_ENTRIES);
      end
      return t;
   endfunction

   localparam mod_tab_type MOD_TAB = build_mod_tab();

   logic [1:0]    spread_mode_ff;
   position_type  position_step_ff;
   logic          swap_red_blue_ff;

   position_type  position_ff, position_in;
   logic          s1_valid_ff, s1_valid_in;
   logic          rsp_tvalid_ff, rsp_tvalid_in;
   colour_type    rsp_tdata_ff;

   logic [OP_W-1:0] req_op;
   logic [7:0]      req_ramp_index;
   colour_type      req_ramp_colour;
   position_type    req_start_position;

   logic          req_fire, rsp_fire, out_free, s1_move;
   logic          pixel_fire, start_fire, ramp_we;
   ramp_addr_type ramp_rd_addr;
   colour_type    ramp_rd_data;

   assign req_op             = req_tuser;
   assign req_ramp_index     = req_tdata[7:0];
   assign req_ramp_colour    = req_tdata[39:8];
   assign req_start_position = req_tdata[71:40];

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid_ff && rsp_tready;

   assign pixel_fire = req_fire && (req_op == OP_NEXT_PIXEL);
   assign start_fire = req_fire && (req_op == OP_START_SPAN);
   assign ramp_we    = req_fire && (req_op == OP_WRITE_RAMP)
                       && (32'(req_ramp_index) < 32'(RAMP_ENTRIES));

   assign ramp_rd_addr = MOD_TAB[spread_index(spread_mode_ff, position_ff)];

   lgsg_ram #(
      .WIDTH (COLOUR_W),
      .DEPTH (RAMP_ENTRIES)
   ) u_ramp (
      .clock   (clock),
      .wr_en   (ramp_we),
      .wr_addr (IDX_W'(req_ramp_index)),
      .wr_data (req_ramp_colour),
      .rd_en   (pixel_fire),
      .rd_addr (ramp_rd_addr),
      .rd_data (ramp_rd_data)
   );

   always_comb begin
      position_in = position_ff;
      if (start_fire) begin
         position_in = req_start_position;
      end else if (pixel_fire) begin
         position_in = position_ff + position_step_ff;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (pixel_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (s1_move) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_fire) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spread_mode_ff   <= MODE_PAD;
         position_step_ff <= '0;
         swap_red_blue_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SPREAD_MODE:   spread_mode_ff   <= csr_wdata[1:0];
            CSR_POSITION_STEP: position_step_ff <= csr_wdata;
            CSR_SWAP_RED_BLUE: swap_red_blue_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         position_ff   <= position_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_tdata_ff <= swap_red_blue_ff ? swap_red_blue(ramp_rd_data) : ramp_rd_data;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   a_pixel_enters_read_stage: assert property (@(posedge clock) disable iff (reset)
      pixel_fire |=> s1_valid_ff)
      else $error("accepted pixel request did not reach the ramp read stage");

   a_stall_blocks_requests: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_tvalid_ff && !rsp_tready) |-> !req_tready)
      else $error("request accepted while read stage is stalled");

   a_read_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> (s1_valid_ff && $stable(ramp_rd_data)))
      else $error("stalled ramp read data lost");

   a_position_holds: assert property (@(posedge clock) disable iff (reset)
      !(pixel_fire || start_fire) |=> $stable(position_ff))
      else $error("gradient position changed without a request");

   a_span_start_loads: assert property (@(posedge clock) disable iff (reset)
      start_fire |=> (position_ff == $past(req_start_position)))
      else $error("span start did not load the position");

endmodule
